[rtl/core/ptk_pkg.sv]
// Package for the paren/name/integer tokenizer: types, codes and character classes.
package ptk_pkg;

  // Scanner mode.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_INT  = 2'd2,
    MODE_DONE = 2'd3
  } mode_t;

  // Token kind codes as they appear on the result channel.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COMMA = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NAME  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EOF   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ERR   = 3'd6;

  // Reported positions are always this wide.
  localparam int OUT_POS_W = 32;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // One result beat.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_POS_W-1:0] start_pos;
    logic [OUT_POS_W-1:0] end_pos;
    logic                 last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

[rtl/core/ptk_if.sv]
// Valid/ready channel interfaces for source bytes and result tokens.
interface ptk_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ptk_token_if;
  logic                               valid;
  logic                               ready;
  logic [ptk_pkg::KIND_W-1:0]    kind;
  logic [ptk_pkg::OUT_POS_W-1:0] start_pos;
  logic [ptk_pkg::OUT_POS_W-1:0] end_pos;
  logic                               last;

  modport source (output valid, output kind, output start_pos, output end_pos,
                  output last, input ready);
  modport sink   (input valid, input kind, input start_pos, input end_pos,
                  input last, output ready);
endinterface

[rtl/core/paren_name_int_tokenizer_unit.sv]
// Top level of the byte-serial tokenizer for parens, commas, names and integers.
//
//   channel  dir  beat payload                          handshake
//   chars    in   char_in[7:0]                          valid/ready
//   tokens   out  kind[2:0] start_pos end_pos last      valid/ready
//
// One source byte is taken per cycle while the queue has room; its tokens go into
// a four-entry result queue in the same cycle and leave one beat per cycle from
// the queue head while the sink is ready. A name or integer closed by a byte that
// is itself a token makes two beats, so the output port sets the sustained rate.
// Bytes are taken whenever the queue has at least two free entries.
// Reset is synchronous and clears the mode, both positions and the queue.
module paren_name_int_tokenizer_unit #(
  parameter int POS_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  ptk_char_if.sink    chars,
  ptk_token_if.source tokens
);
  import ptk_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Scanner state.
  mode_t                mode, mode_next;
  logic [POS_WIDTH-1:0] byte_pos, byte_pos_next;
  logic [POS_WIDTH-1:0] tok_start, tok_start_next;

  // Result queue.
  token_t         queue [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count, count_next;

  logic         accept, pop;
  logic [7:0]   c;
  logic         more, close_tok, emit_tok;
  mode_t        mode_mid;
  logic [POS_WIDTH-1:0] end_val;
  logic [63:0]  pos_ext, start_ext, end_ext;
  token_t       close_beat, own_beat, w0_beat, w1_beat;
  logic         w0_valid, w1_valid;

  assign chars.ready = (count <= (QAW+1)'(QDEPTH - 2));
  assign accept      = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;
  assign c           = chars.char_in;

  assign pos_ext   = 64'(byte_pos);
  assign start_ext = 64'(tok_start);
  assign end_ext   = 64'(end_val);

  // Classify the byte against the current mode and build up to two beats.
  always_comb begin
    more       = 1'b0;
    close_tok  = 1'b0;
    emit_tok   = 1'b0;
    mode_mid   = mode;
    end_val    = (byte_pos > tok_start) ? byte_pos - 1'b1 : tok_start;
    close_beat = '0;
    own_beat   = '0;
    tok_start_next = tok_start;
    mode_next  = mode;

    // A pending name or integer ends on the first byte that cannot extend it.
    close_beat.kind      = (mode == MODE_NAME) ? KIND_NAME : KIND_INT;
    close_beat.start_pos = start_ext[OUT_POS_W-1:0];
    close_beat.end_pos   = end_ext[OUT_POS_W-1:0];
    if (mode == MODE_NAME || mode == MODE_INT) begin
      more = (mode == MODE_NAME) ? (is_letter(c) || is_digit(c)) : is_digit(c);
      if (!more) begin
        close_tok = 1'b1;
        mode_mid  = MODE_IDLE;
      end
    end

    // Single-byte tokens and token starts.
    own_beat.start_pos = pos_ext[OUT_POS_W-1:0];
    own_beat.end_pos   = pos_ext[OUT_POS_W-1:0];
    own_beat.last      = 1'b1;
    mode_next          = mode_mid;
    if (mode_mid == MODE_IDLE) begin
      if (is_space(c)) begin
        emit_tok = 1'b0;
      end else if (c == CH_OPEN) begin
        emit_tok      = 1'b1;
        own_beat.kind = KIND_OPEN;
      end else if (c == CH_CLOSE) begin
        emit_tok      = 1'b1;
        own_beat.kind = KIND_CLOSE;
      end else if (c == CH_COMMA) begin
        emit_tok      = 1'b1;
        own_beat.kind = KIND_COMMA;
      end else if (is_letter(c)) begin
        mode_next      = MODE_NAME;
        tok_start_next = byte_pos;
      end else if (is_digit(c)) begin
        mode_next      = MODE_INT;
        tok_start_next = byte_pos;
      end else if (c == CH_NUL) begin
        emit_tok      = 1'b1;
        own_beat.kind = KIND_EOF;
        mode_next     = MODE_DONE;
      end else begin
        emit_tok      = 1'b1;
        own_beat.kind = KIND_ERR;
        mode_next     = MODE_DONE;
      end
    end
    close_beat.last = !emit_tok;
  end

  // Map the beats onto the two queue write slots.
  assign w0_valid = accept && (close_tok || emit_tok);
  assign w1_valid = accept && close_tok && emit_tok;
  assign w0_beat  = close_tok ? close_beat : own_beat;
  assign w1_beat  = own_beat;

  // The position counter saturates and stops once scanning is done.
  always_comb begin
    byte_pos_next = byte_pos;
    if (accept && mode != MODE_DONE && byte_pos != '1) begin
      byte_pos_next = byte_pos + 1'b1;
    end
  end

  assign count_next = count + (QAW+1)'(w0_valid) + (QAW+1)'(w1_valid)
                      - (QAW+1)'(pop);

  // Control and scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      byte_pos  <= '0;
      tok_start <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (accept && mode != MODE_DONE) begin
        mode      <= mode_next;
        tok_start <= tok_start_next;
      end
      byte_pos <= byte_pos_next;
      wr_ptr   <= wr_ptr + QAW'(w0_valid) + QAW'(w1_valid);
      rd_ptr   <= rd_ptr + QAW'(pop);
      count    <= count_next;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (w0_valid) begin
      queue[wr_ptr] <= w0_beat;
    end
    if (w1_valid) begin
      queue[wr_ptr + 1'b1] <= w1_beat;
    end
  end

  // Queue head drives the result channel.
  assign tokens.valid     = (count != '0);
  assign tokens.kind      = queue[rd_ptr].kind;
  assign tokens.start_pos = queue[rd_ptr].start_pos;
  assign tokens.end_pos   = queue[rd_ptr].end_pos;
  assign tokens.last      = queue[rd_ptr].last;

endmodule

[rtl/core/ptk_checker.sv]
// Port-level checker for the tokenizer and the bind that attaches it.
module ptk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ptk_pkg::KIND_W-1:0]    kind,
  input logic [ptk_pkg::OUT_POS_W-1:0] start_pos,
  input logic [ptk_pkg::OUT_POS_W-1:0] end_pos,
  input logic                            last
);
  import ptk_pkg::*;

  logic term_seen;

  // Remember that a terminating beat (end of file or error) has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_seen <= 1'b0;
    end else if (out_valid && out_ready && (kind == KIND_EOF || kind == KIND_ERR)) begin
      term_seen <= 1'b1;
    end
  end

  // A stalled beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start_pos)
      && $stable(end_pos) && $stable(last))
    else $error("result beat changed while stalled");

  // Terminating tokens are always the final beat of their byte.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EOF || kind == KIND_ERR) |-> last)
    else $error("terminating token not marked last");

  // Nothing follows a terminating token until reset.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    term_seen |-> !out_valid)
    else $error("result after end of file or error");

  // Single-byte tokens span exactly one position.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_OPEN || kind == KIND_CLOSE || kind == KIND_COMMA
      || kind == KIND_EOF || kind == KIND_ERR) |-> start_pos == end_pos)
    else $error("single-byte token with unequal positions");

endmodule

bind paren_name_int_tokenizer_unit ptk_checker u_ptk_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tokens.valid),
  .out_ready (tokens.ready),
  .kind      (tokens.kind),
  .start_pos (tokens.start_pos),
  .end_pos   (tokens.end_pos),
  .last      (tokens.last)
);
